FILE: rtl/rth_pkg.sv
package rth_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int ATAN_LEN      = 24;
	localparam int NUM_ITER      = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

	localparam int XY_W  = 30;
	localparam int Z_W   = 20;
	localparam int IDX_W = 5;
	localparam int DEG_W = 27;
	localparam int SAT_W = 18;
	localparam int Q_W   = 9;
	localparam int DIV_STEPS = Q_W;

	// floor(n / ANG_PI) equals (n * DEG_RECIP) >> DEG_SHIFT for every n below 2**DEG_W.
	localparam int DEG_RECIP = 170891665;
	localparam int DEG_SHIFT = 45;
	localparam int RECIP_W   = 28;
	localparam int PROD_W    = DEG_W + RECIP_W;

	localparam int ANG_PI      = 205887;
	localparam int ANG_HALF_PI = 102944;
	localparam int ANG_TWO_PI  = 411775;
	localparam int SQRT3_Q16   = 113512;
	localparam int HUE_WRAP    = 360;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [8:0] hue_degrees;
		logic [6:0] saturation_percent;
		logic [7:0] intensity;
	} hsi_t;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   flip;
		logic                   zero;
		logic [7:0]             inten;
		logic [16:0]            sat_num;
		logic [9:0]             sum;
	} cordic_t;

	typedef struct packed {
		logic [DEG_W-1:0] deg_num;
		logic [SAT_W-1:0] sat_rem;
		logic [SAT_W-1:0] sat_d;
		logic [Q_W-1:0]   sat_q;
		logic             zero;
		logic [7:0]       inten;
	} div_t;

	function automatic logic [16:0] atan_q16(input logic [IDX_W-1:0] i);
		logic [16:0] a;
		unique case (i)
			5'd0:    a = 17'd51472;
			5'd1:    a = 17'd30385;
			5'd2:    a = 17'd16055;
			5'd3:    a = 17'd8150;
			5'd4:    a = 17'd4091;
			5'd5:    a = 17'd2047;
			5'd6:    a = 17'd1024;
			5'd7:    a = 17'd512;
			5'd8:    a = 17'd256;
			5'd9:    a = 17'd128;
			5'd10:   a = 17'd64;
			5'd11:   a = 17'd32;
			5'd12:   a = 17'd16;
			5'd13:   a = 17'd8;
			5'd14:   a = 17'd4;
			5'd15:   a = 17'd2;
			5'd16:   a = 17'd1;
			default: a = 17'd0;
		endcase
		return a;
	endfunction

endpackage

FILE: rtl/rth_cordic_cell.sv
module rth_cordic_cell import rth_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [IDX_W-1:0] idx,
	input  logic             in_valid,
	input  cordic_t          in_data,
	output logic             out_valid,
	output cordic_t          out_data
);

	cordic_t                nxt;
	logic signed [XY_W-1:0] xs;
	logic signed [XY_W-1:0] ys;
	logic signed [Z_W-1:0]  ang;

	always_comb begin
		xs  = in_data.x >>> idx;
		ys  = in_data.y >>> idx;
		ang = signed'({3'b000, atan_q16(idx)});
		nxt = in_data;
		if (!in_data.y[XY_W-1]) begin
			nxt.x = in_data.x + ys;
			nxt.y = in_data.y - xs;
			nxt.z = in_data.z + ang;
		end else begin
			nxt.x = in_data.x - ys;
			nxt.y = in_data.y + xs;
			nxt.z = in_data.z - ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

FILE: rtl/rth_div_cell.sv
module rth_div_cell import rth_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  div_t in_data,
	output logic out_valid,
	output div_t out_data
);

	div_t nxt;

	// One restoring step of the saturation quotient; the divisor starts shifted up
	// by one less than the quotient width and walks down one place a cell.
	always_comb begin
		nxt = in_data;
		if (in_data.sat_rem >= in_data.sat_d) begin
			nxt.sat_rem = in_data.sat_rem - in_data.sat_d;
			nxt.sat_q   = {in_data.sat_q[Q_W-2:0], 1'b1};
		end else begin
			nxt.sat_q   = {in_data.sat_q[Q_W-2:0], 1'b0};
		end
		nxt.sat_d = in_data.sat_d >> 1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= nxt;
		end
	end

endmodule

FILE: rtl/rgb_to_hsi_pixel_core.sv
// RGB to HSI converter for 8-bit pixels. A pixel request is taken every cycle
// while the result side is not stalled. Its result passes through one input
// stage, one cell per CORDIC iteration, one stage that folds the angle into
// degrees, nine restoring-division cells and the output register. The whole
// chain advances together, so a stall on the result side holds every stage.
// Hue is in truncated whole degrees and is zero for grey or black pixels.
module rgb_to_hsi_pixel_core import rth_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pix_valid,
	output logic   pix_stall,
	input  pixel_t pix,
	output logic   hsi_valid,
	input  logic   hsi_stall,
	output hsi_t   hsi
);

	logic en;
	assign en        = !(hsi_valid && hsi_stall);
	assign pix_stall = !en;

	// input stage
	logic [9:0]             sum;
	logic [7:0]             mn;
	logic signed [10:0]     dx;
	logic signed [8:0]      dgb;
	logic [7:0]             agb;
	logic [24:0]            ymul;
	logic signed [XY_W-1:0] x0;
	logic signed [XY_W-1:0] y0;
	logic [19:0]            int_mul;
	logic [9:0]             spread;
	cordic_t                pre;

	always_comb begin
		sum = 10'(pix.red) + 10'(pix.green) + 10'(pix.blue);
		mn  = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		dx   = signed'({2'b00, pix.red, 1'b0}) - signed'({3'b000, pix.green})
		     - signed'({3'b000, pix.blue});
		dgb  = signed'({1'b0, pix.green}) - signed'({1'b0, pix.blue});
		agb  = dgb[8] ? 8'(-dgb) : dgb[7:0];
		ymul = 25'(agb) * 25'(SQRT3_Q16);
		x0   = signed'({{(XY_W-27){dx[10]}}, dx, 16'b0});
		y0   = signed'({{(XY_W-25){1'b0}}, ymul});
		// sum/3 by reciprocal; exact for sums up to 765
		int_mul = 20'(sum) * 20'd683;
		spread  = sum - 10'(3 * mn);

		pre.flip    = pix.blue > pix.green;
		pre.zero    = (sum == 10'd0) || (spread == 10'd0);
		pre.inten   = int_mul[18:11];
		pre.sat_num = 17'(spread) * 17'd100;
		pre.sum     = sum;
		if (x0[XY_W-1]) begin
			// left half-plane: turn by a quarter first
			pre.x = y0;
			pre.y = -x0;
			pre.z = Z_W'(ANG_HALF_PI);
		end else begin
			pre.x = x0;
			pre.y = y0;
			pre.z = '0;
		end
	end

	logic    c_valid [NUM_ITER+1];
	cordic_t c_data  [NUM_ITER+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_valid[0] <= 1'b0;
		end else if (en) begin
			c_valid[0] <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_data[0] <= pre;
		end
	end

	for (genvar i = 0; i < NUM_ITER; i++) begin : g_cordic
		rth_cordic_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.idx       (IDX_W'(i)),
			.in_valid  (c_valid[i]),
			.in_data   (c_data[i]),
			.out_valid (c_valid[i+1]),
			.out_data  (c_data[i+1])
		);
	end

	// angle clamp, mirror and scaling to degree numerator
	cordic_t         last;
	logic [Z_W-1:0]  zc;
	logic [Z_W-1:0]  hue_ang;
	div_t            dstart;

	always_comb begin
		last = c_data[NUM_ITER];
		priority if (last.z[Z_W-1]) begin
			zc = '0;
		end else if (last.z > Z_W'(ANG_PI)) begin
			zc = Z_W'(ANG_PI);
		end else begin
			zc = last.z;
		end
		hue_ang = last.flip ? (Z_W'(ANG_TWO_PI) - zc) : zc;

		dstart.deg_num = DEG_W'(hue_ang) * DEG_W'(180);
		dstart.sat_rem = SAT_W'(last.sat_num);
		dstart.sat_d   = SAT_W'(last.sum) << (Q_W - 1);
		dstart.sat_q   = '0;
		dstart.zero    = last.zero;
		dstart.inten   = last.inten;
	end

	logic d_valid [DIV_STEPS+1];
	div_t d_data  [DIV_STEPS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_valid[0] <= 1'b0;
		end else if (en) begin
			d_valid[0] <= c_valid[NUM_ITER];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_data[0] <= dstart;
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		rth_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (d_valid[j]),
			.in_data   (d_data[j]),
			.out_valid (d_valid[j+1]),
			.out_data  (d_data[j+1])
		);
	end

	// output register
	div_t              fin;
	hsi_t              res;
	logic [PROD_W-1:0] deg_prod;
	logic [Q_W-1:0]    deg_q;

	always_comb begin
		fin = d_data[DIV_STEPS];
		// The degree quotient comes from a reciprocal multiply by 1/pi.
		deg_prod = PROD_W'(fin.deg_num) * PROD_W'(DEG_RECIP);
		deg_q    = deg_prod[DEG_SHIFT +: Q_W];
		res.intensity = fin.inten;
		if (fin.zero) begin
			res.hue_degrees        = '0;
			res.saturation_percent = '0;
		end else begin
			res.hue_degrees = (deg_q >= Q_W'(HUE_WRAP)) ?
				(deg_q - Q_W'(HUE_WRAP)) : deg_q;
			res.saturation_percent = fin.sat_q[6:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsi_valid <= 1'b0;
		end else if (en) begin
			hsi_valid <= d_valid[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hsi <= res;
		end
	end

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsi_valid |-> hsi.hue_degrees < 9'd360)
		else $error("hue out of range");

	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsi_valid |-> hsi.saturation_percent <= 7'd100)
		else $error("saturation out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(hsi_valid && hsi_stall) |=> (hsi_valid && $stable(hsi)))
		else $error("stalled result changed");

endmodule

FILE: tb/tb_rgb_to_hsi_pixel_core.sv
module tb_rgb_to_hsi_pixel_core;
	import rth_pkg::*;

	logic   clk;
	logic   arst_n;
	logic   pix_valid;
	logic   pix_stall;
	pixel_t pix;
	logic   hsi_valid;
	logic   hsi_stall;
	hsi_t   hsi;

	hsi_t   hsi_expected_q[$];
	int     mismatch_count;
	int     cycle_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	int     hold_off_cycles;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 40;

	rgb_to_hsi_pixel_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.hsi_valid (hsi_valid),
		.hsi_stall (hsi_stall),
		.hsi       (hsi)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	localparam longint ATAN_TAB[24] = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};

	// Vectoring CORDIC on the chroma plane; >>> on longint floors, as required.
	function automatic logic [8:0] hue_angle(input longint r, input longint g, input longint b);
		longint x, y, z, t, xs, ys, h, d, dgb;
		x = (2 * r - g - b) * 65536;
		dgb = g - b;
		y = (dgb < 0 ? -dgb : dgb) * SQRT3_Q16;
		z = 0;
		if (x < 0) begin
			t = x;
			x = y;
			y = -t;
			z = ANG_HALF_PI;
		end
		for (int i = 0; i < NUM_ITER; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_TAB[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_TAB[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > ANG_PI)
			z = ANG_PI;
		h = (b > g) ? (ANG_TWO_PI - z) : z;
		d = (h * 180) / ANG_PI;
		if (d >= HUE_WRAP)
			d -= HUE_WRAP;
		return d[8:0];
	endfunction

	function automatic hsi_t pixel_to_hsi(input pixel_t p);
		hsi_t   res;
		longint r, g, b, sum, mn;
		r = p.red;
		g = p.green;
		b = p.blue;
		sum = r + g + b;
		mn = r;
		if (g < mn)
			mn = g;
		if (b < mn)
			mn = b;
		res = '0;
		res.intensity = 8'(sum / 3);
		if (sum != 0 && sum != 3 * mn) begin
			res.saturation_percent = 7'((100 * (sum - 3 * mn)) / sum);
			res.hue_degrees = hue_angle(r, g, b);
		end
		return res;
	endfunction

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
		pixel_t p;
		p.red = r;
		p.green = g;
		p.blue = b;
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		hsi_expected_q.insert(hsi_expected_q.size(), pixel_to_hsi(p));
	endtask

	task automatic wait_drained();
		if (pix_valid)
			pix_valid <= 1'b0;
		while (hsi_expected_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random(input int n);
		logic [7:0] r, g, b;
		for (int k = 0; k < n; k++) begin
			r = 8'($urandom);
			g = 8'($urandom);
			b = 8'($urandom);
			case ($urandom_range(9))
				0: g = r;
				1: b = g;
				2: begin
					g = r;
					b = r;
				end
				3: b = 8'd0;
				4: r = g + 8'($urandom_range(2));
				default: ;
			endcase
			send_pixel(r, g, b);
		end
	endtask

	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd1, 8'd1);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd2);
		send_pixel(8'd10, 8'd200, 8'd100);
		send_pixel(8'd170, 8'd85, 8'd85);
		send_pixel(8'd85, 8'd170, 8'd170);
		send_pixel(8'd100, 8'd101, 8'd100);
		send_pixel(8'd200, 8'd201, 8'd202);
		wait_drained();
	endtask

	task automatic test_full_rate();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_random(200);
		wait_drained();
	endtask

	task automatic test_sender_idle();
		send_idle_pct = 84;
		recv_stall_pct = 0;
		send_random(150);
	endtask

	task automatic test_receiver_stall();
		send_idle_pct = 0;
		recv_stall_pct = 84;
		send_random(150);
	endtask

	task automatic test_both_idle();
		send_idle_pct = 28;
		recv_stall_pct = 28;
		send_random(200);
	endtask

	// The receiver is held off long enough for the pipe to fill and back up.
	task automatic test_long_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 120;
		send_random(100);
		wait_drained();
	endtask

	initial begin
		hsi_stall = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hsi_stall <= 1'b1;
				hold_off_cycles--;
			end else begin
				hsi_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		hsi_t exp_res;
		if (arst_n && hsi_valid && !hsi_stall) begin
			if (hsi_expected_q.size() == 0) begin
				$error("unexpected result hsi=%h", hsi);
				mismatch_count++;
			end else begin
				exp_res = hsi_expected_q.pop_front();
				if (hsi.hue_degrees !== exp_res.hue_degrees) begin
					$error("hue_degrees expected %0d actual %0d",
						exp_res.hue_degrees, hsi.hue_degrees);
					mismatch_count++;
				end
				if (hsi.saturation_percent !== exp_res.saturation_percent) begin
					$error("saturation_percent expected %0d actual %0d",
						exp_res.saturation_percent, hsi.saturation_percent);
					mismatch_count++;
				end
				if (hsi.intensity !== exp_res.intensity) begin
					$error("intensity expected %0d actual %0d",
						exp_res.intensity, hsi.intensity);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		mismatch_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_off_cycles = 0;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_rate();
		test_sender_idle();
		test_receiver_stall();
		test_both_idle();
		test_long_hold_off();
		recv_stall_pct = 0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && hsi_expected_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
